### design/bmrsd_pkg.sv
// Shared types, codes and helpers for the bitmap record stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package bmrsd_pkg;

	localparam int MAX_SENSORS_DEF = 32;
	localparam int NCOLS = 32;
	localparam int QDEPTH = 4;

	localparam logic [7:0] TAG_DATA = 8'h64;
	localparam logic [7:0] TAG_END  = 8'h58;

	localparam logic [1:0] CFG_SENSOR_COUNT = 2'd0;
	localparam logic [1:0] CFG_REPAIR       = 2'd1;
	localparam logic [1:0] CFG_BIG_ENDIAN   = 2'd2;

	localparam logic [1:0] KIND_NEW     = 2'd0;
	localparam logic [1:0] KIND_REPEAT  = 2'd1;
	localparam logic [1:0] KIND_ROW_END = 2'd2;
	localparam logic [1:0] KIND_STOP    = 2'd3;

	localparam logic [1:0] CODE_REPEAT = 2'd1;
	localparam logic [1:0] CODE_NEW    = 2'd2;

	localparam logic OP_TABLE = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	localparam logic [1:0] SZ_1 = 2'd0;
	localparam logic [1:0] SZ_2 = 2'd1;
	localparam logic [1:0] SZ_4 = 2'd2;
	localparam logic [1:0] SZ_8 = 2'd3;

	localparam logic [63:0] NAN32 = 64'h0000_0000_7FC0_0000;
	localparam logic [63:0] NAN64 = 64'h7FF8_0000_0000_0000;

	typedef struct packed {
		logic [1:0] size_code;
		logic       counts_for_row;
		logic       keep_column;
		logic [4:0] column_number;
	} entry_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic [4:0] sensor_slot;
		entry_t     entry;
	} item_t;

	typedef struct packed {
		logic [5:0] sensor_count;
		logic       repair_enable;
		logic       values_big_endian;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  column;
		logic [1:0]  size_code;
		logic [63:0] value_bits;
		logic        value_valid;
		logic        row_kept;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {PH_WAIT, PH_SKIP, PH_HEADER, PH_VALUE, PH_STOPPED} phase_t;
	typedef enum logic [1:0] {BK_IDLE, BK_WALK, BK_FLUSH} bstate_t;

	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		logic [63:0] m;
		unique case (sz)
			SZ_1: m = 64'h0000_0000_0000_00FF;
			SZ_2: m = 64'h0000_0000_0000_FFFF;
			SZ_4: m = 64'h0000_0000_FFFF_FFFF;
			SZ_8: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	// Infinities of either sign become the canonical quiet NaN.
	function automatic logic [63:0] fix_inf(input logic [63:0] v, input logic [1:0] sz);
		logic [63:0] r;
		r = v;
		if (sz == SZ_4 && v[30:0] == 31'h7F80_0000) r = NAN32;
		if (sz == SZ_8 && v[62:0] == 63'h7FF0_0000_0000_0000) r = NAN64;
		return r;
	endfunction

endpackage
`default_nettype wire

### design/bmrsd_front.sv
// Front part: accepts items, packs the table entry and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module bmrsd_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                op,
	input  wire logic [7:0]          data_byte,
	input  wire logic [4:0]          sensor_slot,
	input  wire logic [1:0]          size_code,
	input  wire logic                counts_for_row,
	input  wire logic                keep_column,
	input  wire logic [4:0]          column_number,
	output logic                     q_valid,
	output bmrsd_pkg::item_t         q_item,
	input  wire logic                q_pop
);
	localparam int QAW = $clog2(bmrsd_pkg::QDEPTH);

	bmrsd_pkg::item_t  mem_q [bmrsd_pkg::QDEPTH];
	logic [QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QAW:0]      count_q;
	logic              push;
	bmrsd_pkg::item_t  new_item;

	assign in_stall = (count_q == (QAW+1)'(bmrsd_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		new_item.op                   = op;
		new_item.data_byte            = data_byte;
		new_item.sensor_slot          = sensor_slot;
		new_item.entry.size_code      = size_code;
		new_item.entry.counts_for_row = counts_for_row;
		new_item.entry.keep_column    = keep_column;
		new_item.entry.column_number  = column_number;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= new_item;
	end
endmodule
`default_nettype wire

### design/bmrsd_back.sv
// Back part: record decoder state machine, sensor walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module bmrsd_back #(
	parameter int MAX_SENSORS = bmrsd_pkg::MAX_SENSORS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bmrsd_pkg::cfg_t   cfg,
	input  wire logic              q_valid,
	input  wire bmrsd_pkg::item_t  q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bmrsd_pkg::result_t     out_res
);
	localparam int SW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int WW  = $clog2(MAX_SENSORS + 1);
	localparam int HBW = $clog2((MAX_SENSORS + 3) / 4 + 1);

	bmrsd_pkg::bstate_t state_q, state_d;
	bmrsd_pkg::phase_t  phase_q, phase_d;
	logic [HBW-1:0]     hbc_q, hbc_d;
	logic [WW-1:0]      walk_q, walk_d;
	logic [3:0]         vcount_q, vcount_d;
	logic [63:0]        acc_q, acc_d;
	logic               keep_q, keep_d;

	logic [1:0]              hc_q   [MAX_SENSORS];
	bmrsd_pkg::entry_t       tab_q  [MAX_SENSORS];
	logic [63:0]             prev_q [bmrsd_pkg::NCOLS];
	logic [bmrsd_pkg::NCOLS-1:0] pv_q;

	bmrsd_pkg::result_t pend_q, new_res, last_res;
	logic               pend_v_q, out_v_q;
	logic               can_emit, room, produce, flush, hdr_we, tab_we, prev_we;

	logic [WW-1:0]      n;
	logic [HBW-1:0]     hdr_bytes;
	logic [HBW-1:0]     hbc_next;
	logic [SW-1:0]      walk_idx, tab_idx;
	bmrsd_pkg::entry_t  cur;
	logic [1:0]         cur_code;
	logic [63:0]        acc_next, val_done;
	logic [3:0]         vcount_next;
	logic [7:0]         b;

	always_comb begin
		if (cfg.sensor_count == 6'd0) n = WW'(1);
		else if (7'(cfg.sensor_count) > 7'(MAX_SENSORS)) n = WW'(MAX_SENSORS);
		else n = WW'(cfg.sensor_count);
	end

	assign hdr_bytes   = HBW'((7'(n) + 7'd3) >> 2);
	assign hbc_next    = hbc_q + 1'b1;
	assign walk_idx    = walk_q[SW-1:0];
	assign tab_idx     = SW'(q_item.sensor_slot);
	assign cur         = tab_q[walk_idx];
	assign cur_code    = hc_q[walk_idx];
	assign b           = q_item.data_byte;
	assign vcount_next = vcount_q + 1'b1;
	assign acc_next    = cfg.values_big_endian ? {acc_q[55:0], b}
	                   : (acc_q | ({56'd0, b} << {vcount_q[2:0], 3'b000}));
	assign val_done    = bmrsd_pkg::fix_inf(acc_next & bmrsd_pkg::size_mask(cur.size_code),
	                                        cur.size_code);

	assign can_emit  = !out_v_q || !out_stall;
	assign room      = !pend_v_q || can_emit;
	assign out_valid = out_v_q;

	always_comb begin
		last_res      = pend_q;
		last_res.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bmrsd_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		hbc_d    = hbc_q;
		walk_d   = walk_q;
		vcount_d = vcount_q;
		acc_d    = acc_q;
		keep_d   = keep_q;
		q_pop    = 1'b0;
		hdr_we   = 1'b0;
		tab_we   = 1'b0;
		prev_we  = 1'b0;
		produce  = 1'b0;
		flush    = 1'b0;
		new_res  = '0;
		unique case (state_q)
			bmrsd_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.op == bmrsd_pkg::OP_TABLE) begin
						tab_we = (32'(q_item.sensor_slot) < MAX_SENSORS);
					end else begin
						unique case (phase_q)
							bmrsd_pkg::PH_WAIT, bmrsd_pkg::PH_SKIP: begin
								if (b == bmrsd_pkg::TAG_DATA) begin
									phase_d = bmrsd_pkg::PH_HEADER;
									hbc_d   = '0;
									walk_d  = '0;
									keep_d  = 1'b0;
								end else if (phase_q == bmrsd_pkg::PH_WAIT) begin
									if (b == bmrsd_pkg::TAG_END || !cfg.repair_enable) begin
										produce      = 1'b1;
										new_res.kind = bmrsd_pkg::KIND_STOP;
										phase_d      = bmrsd_pkg::PH_STOPPED;
										state_d      = bmrsd_pkg::BK_FLUSH;
									end else begin
										phase_d = bmrsd_pkg::PH_SKIP;
									end
								end
							end
							bmrsd_pkg::PH_HEADER: begin
								hdr_we = 1'b1;
								hbc_d  = hbc_next;
								if (hbc_next >= hdr_bytes) begin
									walk_d  = '0;
									state_d = bmrsd_pkg::BK_WALK;
								end
							end
							bmrsd_pkg::PH_VALUE: begin
								if (vcount_next >= (4'd1 << cur.size_code)) begin
									if (cur.keep_column) begin
										produce             = 1'b1;
										prev_we             = 1'b1;
										new_res.kind        = bmrsd_pkg::KIND_NEW;
										new_res.column      = cur.column_number;
										new_res.size_code   = cur.size_code;
										new_res.value_bits  = val_done;
										new_res.value_valid = 1'b1;
									end
									vcount_d = '0;
									acc_d    = '0;
									walk_d   = walk_q + 1'b1;
									state_d  = bmrsd_pkg::BK_WALK;
								end else begin
									vcount_d = vcount_next;
									acc_d    = acc_next;
								end
							end
							default: ;
						endcase
					end
				end
			end
			bmrsd_pkg::BK_WALK: begin
				if (room) begin
					if (walk_q >= n) begin
						produce          = 1'b1;
						new_res.kind     = bmrsd_pkg::KIND_ROW_END;
						new_res.row_kept = keep_q;
						phase_d          = bmrsd_pkg::PH_WAIT;
						state_d          = bmrsd_pkg::BK_FLUSH;
					end else if (cur_code == bmrsd_pkg::CODE_REPEAT) begin
						if (cur.counts_for_row) keep_d = 1'b1;
						if (cur.keep_column) begin
							produce             = 1'b1;
							new_res.kind        = bmrsd_pkg::KIND_REPEAT;
							new_res.column      = cur.column_number;
							new_res.size_code   = cur.size_code;
							new_res.value_valid = pv_q[cur.column_number];
							new_res.value_bits  = pv_q[cur.column_number]
							                    ? prev_q[cur.column_number] : 64'd0;
						end
						walk_d = walk_q + 1'b1;
					end else if (cur_code == bmrsd_pkg::CODE_NEW) begin
						if (cur.counts_for_row) keep_d = 1'b1;
						vcount_d = '0;
						acc_d    = '0;
						phase_d  = bmrsd_pkg::PH_VALUE;
						state_d  = bmrsd_pkg::BK_FLUSH;
					end else begin
						walk_d = walk_q + 1'b1;
					end
				end
			end
			bmrsd_pkg::BK_FLUSH: begin
				if (room) begin
					flush   = 1'b1;
					state_d = bmrsd_pkg::BK_IDLE;
				end
			end
			default: state_d = bmrsd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bmrsd_pkg::PH_WAIT;
			hbc_q    <= '0;
			walk_q   <= '0;
			vcount_q <= '0;
			acc_q    <= '0;
			keep_q   <= 1'b0;
			pv_q     <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			hbc_q    <= hbc_d;
			walk_q   <= walk_d;
			vcount_q <= vcount_d;
			acc_q    <= acc_d;
			keep_q   <= keep_d;
			if (prev_we) pv_q[cur.column_number] <= 1'b1;
			if ((produce || flush) && pend_v_q) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
			if (produce) pend_v_q <= 1'b1;
			else if (flush) pend_v_q <= 1'b0;
		end
	end

	// A held result goes out with last clear when another one follows it,
	// and with last set when the item is finished.
	always_ff @(posedge clk) begin
		if (produce) begin
			pend_q <= new_res;
			if (pend_v_q) out_res <= pend_q;
		end else if (flush && pend_v_q) begin
			out_res <= last_res;
		end
		if (tab_we) tab_q[tab_idx] <= q_item.entry;
		if (prev_we) prev_q[cur.column_number] <= val_done;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			if (hdr_we && (i / 4) == int'(hbc_q) && i < int'(n))
				hc_q[i] <= b[6 - 2 * (i % 4) +: 2];
		end
	end
endmodule
`default_nettype wire

### design/bitmap_record_stream_decoder_core.sv
// Top level of the bitmap record stream decoder: configuration registers and the two parts.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | op, data_byte, sensor_slot, size_code,
//          |           |                     | counts_for_row, keep_column, column_number
//  out     | output    | out_valid/out_stall | kind, out_column, out_size_code, value_bits,
//          |           |                     | value_valid, row_kept, last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The back part pops a table write, tag, header or value byte in its idle state.
// A tag that stops the stream then closes out the stop result in the flush state.
// After the last byte of a header or value the back part walks the sensors, then gives
// the row end or goes on to the next new sensor, and closes out the last result; the
// sensor walk sets the rate, and a stalled output holds the walk.
// A four-beat queue lets the input keep moving while the back part walks or stalls.
// Reset clears the decoder to wait for a tag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_record_stream_decoder_core #(
	parameter int MAX_SENSORS = bmrsd_pkg::MAX_SENSORS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  data_byte,
	input  wire logic [4:0]  sensor_slot,
	input  wire logic [1:0]  size_code,
	input  wire logic        counts_for_row,
	input  wire logic        keep_column,
	input  wire logic [4:0]  column_number,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [4:0]       out_column,
	output logic [1:0]       out_size_code,
	output logic [63:0]      value_bits,
	output logic             value_valid,
	output logic             row_kept,
	output logic             last
);
	bmrsd_pkg::cfg_t    cfg_q;
	bmrsd_pkg::item_t   q_item;
	bmrsd_pkg::result_t out_res;
	logic               q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_count      <= 6'd1;
			cfg_q.repair_enable     <= 1'b0;
			cfg_q.values_big_endian <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bmrsd_pkg::CFG_SENSOR_COUNT: cfg_q.sensor_count      <= cfg_data;
				bmrsd_pkg::CFG_REPAIR:       cfg_q.repair_enable     <= cfg_data[0];
				bmrsd_pkg::CFG_BIG_ENDIAN:   cfg_q.values_big_endian <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bmrsd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_byte      (data_byte),
		.sensor_slot    (sensor_slot),
		.size_code      (size_code),
		.counts_for_row (counts_for_row),
		.keep_column    (keep_column),
		.column_number  (column_number),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	bmrsd_back #(.MAX_SENSORS(MAX_SENSORS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind          = out_res.kind;
	assign out_column    = out_res.column;
	assign out_size_code = out_res.size_code;
	assign value_bits    = out_res.value_bits;
	assign value_valid   = out_res.value_valid;
	assign row_kept      = out_res.row_kept;
	assign last          = out_res.last;

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == bmrsd_pkg::KIND_ROW_END || kind == bmrsd_pkg::KIND_STOP)
		|-> last) else $error("row end or stop beat without last");

	a_kept_only_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != bmrsd_pkg::KIND_ROW_END |-> !row_kept)
		else $error("row_kept set outside a row end");

	a_unset_repeat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == bmrsd_pkg::KIND_REPEAT && !value_valid |-> value_bits == 64'd0)
		else $error("repeat of unset column carries value bits");
`endif
endmodule
`default_nettype wire
